// ===== rtl/tob_pkg.sv =====
// Shared types and constants for the tile occupancy bitmap.
package tob_pkg;

    localparam int COORD_W    = 5;
    localparam int SIZE_W     = 6;
    localparam int COUNT_W    = 16;
    localparam int MAX_STRIPS = 16;
    localparam int STRIP_N_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_DRAIN = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT,
        ST_D_LOAD,
        ST_D_FIND,
        ST_D_MERGE0,
        ST_D_MERGE,
        ST_D_EMIT
    } state_t;

    // Strobes from the sequencer to the row memory.
    typedef struct packed {
        logic re;
        logic we;
        logic clr;
    } mem_ctl_t;

endpackage

// ===== rtl/tob_row_mem.sv =====
// Row mask memory with one read and one write port, per-row valid bits and bulk clear.
module tob_row_mem #(
    parameter int TILES = 32,
    localparam int AW = $clog2(TILES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tob_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]      raddr,
    input  logic [AW-1:0]      waddr,
    input  logic [TILES-1:0]   wdata,
    output logic [TILES-1:0]   rdata
);
    import tob_pkg::*;

    logic [TILES-1:0] mem [TILES];
    logic [TILES-1:0] vld_reg;
    logic [TILES-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic             fwd;

    assign fwd = ctl.we && (waddr == raddr);

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rd_data_reg <= fwd ? wdata : mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                vld_reg <= '0;
            end
            else if (ctl.we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (ctl.re)
            begin
                rd_vld_reg <= fwd ? 1'b1 : vld_reg[raddr];
            end
        end
    end

    // A row never written since the last clear reads as empty.
    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/tile_occupancy_bitmap.sv =====
// Tile occupancy bitmap: mark, query, clear and strip drain over a grid of row masks.
// Mark and query read one memory row a cycle over the rows in range; a query with no
// marks or with tile testing off skips the walk. Drain reads, per strip, the rows below
// it; an empty drain reads none. Output stalls hold each result. One item is in work at
// a time.
// Reset clears the grid, the mark count and the output through per-row valid bits;
// tile testing comes out of reset enabled.
module tile_occupancy_bitmap #(
    parameter int TILES = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [tob_pkg::COORD_W-1:0]  tile_x_first,
    input  logic [tob_pkg::COORD_W-1:0]  tile_x_last,
    input  logic [tob_pkg::COORD_W-1:0]  tile_y_first,
    input  logic [tob_pkg::COORD_W-1:0]  tile_y_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic                         strip_valid,
    output logic [tob_pkg::COORD_W-1:0]  rect_x,
    output logic [tob_pkg::COORD_W-1:0]  rect_y,
    output logic [tob_pkg::SIZE_W-1:0]   rect_width,
    output logic [tob_pkg::SIZE_W-1:0]   rect_height,
    output logic [tob_pkg::COUNT_W-1:0]  mark_count,
    output logic                         last
);
    import tob_pkg::*;

    localparam int AW = $clog2(TILES);

    function automatic logic [AW-1:0] clamp_tile(input logic [COORD_W-1:0] v);
        if (7'(v) > 7'(TILES - 1))
        begin
            return AW'(TILES - 1);
        end
        return AW'(v);
    endfunction

    function automatic logic [TILES-1:0] span_mask(input logic [AW-1:0] f,
                                                   input logic [AW-1:0] l);
        logic [TILES-1:0] full;
        full = '1;
        return (full >> (AW'(TILES - 1) - l)) & (full << f);
    endfunction

    function automatic logic [AW-1:0] onehot_enc(input logic [TILES-1:0] v);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < TILES; i++)
        begin
            if (v[i])
            begin
                idx = idx | AW'(i);
            end
        end
        return idx;
    endfunction

    // Column just past the strip, or TILES when the strip reaches the right edge.
    function automatic logic [AW:0] strip_end(input logic [TILES-1:0] s);
        logic [TILES-1:0] e;
        e = (s << 1) & ~s;
        if (e == '0)
        begin
            return (AW+1)'(TILES);
        end
        return {1'b0, onehot_enc(e)};
    endfunction

    state_t               state_reg, state_next;
    logic                 enable_reg;
    logic [COUNT_W-1:0]   count_reg, count_next;
    opcode_t              op_reg, op_next;
    logic [TILES-1:0]     xmask_reg, xmask_next;
    logic [AW:0]          y_rd_reg, y_rd_next;
    logic [AW-1:0]        y_last_reg, y_last_next;
    logic [AW-1:0]        y_wr_reg, y_wr_next;
    logic                 chk_reg, chk_next;
    logic                 hit_acc_reg, hit_acc_next;
    logic [AW-1:0]        row_reg, row_next;
    logic [TILES-1:0]     pend_reg, pend_next;
    logic [TILES-1:0]     strip_reg, strip_next;
    logic [AW-1:0]        xs_reg, xs_next;
    logic [AW:0]          xend_reg, xend_next;
    logic [AW:0]          yend_reg, yend_next;
    logic [STRIP_N_W-1:0] n_reg, n_next;

    logic                 o_valid_reg;
    logic                 o_hit_reg;
    logic                 o_strip_valid_reg;
    logic [COORD_W-1:0]   o_x_reg;
    logic [COORD_W-1:0]   o_y_reg;
    logic [SIZE_W-1:0]    o_w_reg;
    logic [SIZE_W-1:0]    o_h_reg;
    logic [COUNT_W-1:0]   o_count_reg;
    logic                 o_last_reg;

    logic                 load;
    logic                 ld_hit;
    logic                 ld_strip_valid;
    logic [COORD_W-1:0]   ld_x;
    logic [COORD_W-1:0]   ld_y;
    logic [SIZE_W-1:0]    ld_w;
    logic [SIZE_W-1:0]    ld_h;
    logic                 ld_last;

    mem_ctl_t             mem_ctl;
    logic [AW-1:0]        mem_raddr;
    logic [AW-1:0]        mem_waddr;
    logic [TILES-1:0]     mem_wdata;
    logic [TILES-1:0]     mem_rdata;

    logic                 out_free;
    logic [AW-1:0]        x0, x1, y0, y1;
    logic [TILES-1:0]     low_bit;
    logic [TILES-1:0]     run_mask;
    logic [AW:0]          row_plus1;
    logic [AW:0]          yend_plus1;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !o_valid_reg || !out_stall;

    assign x0 = clamp_tile(tile_x_first);
    assign x1 = clamp_tile(tile_x_last);
    assign y0 = clamp_tile(tile_y_first);
    assign y1 = clamp_tile(tile_y_last);

    // Lowest run of set bits: isolate the lowest one, then let the carry ripple through the run.
    assign low_bit  = pend_reg & (~pend_reg + TILES'(1));
    assign run_mask = pend_reg & ~(pend_reg + low_bit);

    assign row_plus1  = {1'b0, row_reg} + (AW+1)'(1);
    assign yend_plus1 = yend_reg + (AW+1)'(1);

    tob_row_mem #(
        .TILES (TILES)
    ) u_row_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        xmask_next   = xmask_reg;
        y_rd_next    = y_rd_reg;
        y_last_next  = y_last_reg;
        y_wr_next    = y_wr_reg;
        chk_next     = chk_reg;
        hit_acc_next = hit_acc_reg;
        row_next     = row_reg;
        pend_next    = pend_reg;
        strip_next   = strip_reg;
        xs_next      = xs_reg;
        xend_next    = xend_reg;
        yend_next    = yend_reg;
        n_next       = n_reg;

        mem_ctl   = '0;
        mem_raddr = '0;
        mem_waddr = '0;
        mem_wdata = '0;

        load           = 1'b0;
        ld_hit         = 1'b0;
        ld_strip_valid = 1'b0;
        ld_x           = '0;
        ld_y           = '0;
        ld_w           = '0;
        ld_h           = '0;
        ld_last        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    hit_acc_next = 1'b0;
                    op_next      = opcode_t'(opcode);
                    xmask_next   = span_mask(x0, x1);
                    y_rd_next    = {1'b0, y0};
                    y_last_next  = y1;
                    chk_next     = 1'b0;
                    case (opcode_t'(opcode))
                        OP_CLEAR:
                        begin
                            mem_ctl.clr = 1'b1;
                            count_next  = '0;
                            state_next  = ST_RESULT;
                        end
                        OP_MARK:
                        begin
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                            state_next = ST_WALK;
                        end
                        OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_RESULT;
                            end
                            else if (!enable_reg)
                            begin
                                hit_acc_next = 1'b1;
                                state_next   = ST_RESULT;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        OP_DRAIN:
                        begin
                            // The drain row is taken as given; a row past the grid is empty.
                            if (7'(tile_y_first) >= 7'(TILES))
                            begin
                                state_next = ST_RESULT;
                            end
                            else
                            begin
                                row_next    = AW'(tile_y_first);
                                mem_ctl.re  = 1'b1;
                                mem_raddr   = AW'(tile_y_first);
                                n_next      = '0;
                                state_next  = ST_D_LOAD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // Data for the row read last cycle arrives now; the next row is read meanwhile.
                if (chk_reg)
                begin
                    if (op_reg == OP_MARK)
                    begin
                        mem_ctl.we = 1'b1;
                        mem_waddr  = y_wr_reg;
                        mem_wdata  = mem_rdata | xmask_reg;
                    end
                    else if ((mem_rdata & xmask_reg) != '0)
                    begin
                        hit_acc_next = 1'b1;
                    end
                end
                if (y_rd_reg <= {1'b0, y_last_reg})
                begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = y_rd_reg[AW-1:0];
                    y_wr_next  = y_rd_reg[AW-1:0];
                    y_rd_next  = y_rd_reg + (AW+1)'(1);
                    chk_next   = 1'b1;
                end
                else
                begin
                    chk_next   = 1'b0;
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_hit     = hit_acc_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_D_LOAD:
            begin
                pend_next = mem_rdata;
                if (mem_rdata == '0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_D_FIND;
                end
            end

            ST_D_FIND:
            begin
                strip_next = run_mask;
                xs_next    = onehot_enc(low_bit);
                pend_next  = pend_reg & ~run_mask;
                state_next = ST_D_MERGE0;
            end

            ST_D_MERGE0:
            begin
                // The drained row holds exactly what is still pending.
                mem_ctl.we = 1'b1;
                mem_waddr  = row_reg;
                mem_wdata  = pend_reg;
                xend_next  = strip_end(strip_reg);
                yend_next  = row_plus1;
                if (row_plus1 < (AW+1)'(TILES))
                begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = row_plus1[AW-1:0];
                    state_next = ST_D_MERGE;
                end
                else
                begin
                    state_next = ST_D_EMIT;
                end
            end

            ST_D_MERGE:
            begin
                if ((mem_rdata & strip_reg) == strip_reg)
                begin
                    mem_ctl.we = 1'b1;
                    mem_waddr  = yend_reg[AW-1:0];
                    mem_wdata  = mem_rdata & ~strip_reg;
                    yend_next  = yend_plus1;
                    if (yend_plus1 < (AW+1)'(TILES))
                    begin
                        mem_ctl.re = 1'b1;
                        mem_raddr  = yend_plus1[AW-1:0];
                    end
                    else
                    begin
                        state_next = ST_D_EMIT;
                    end
                end
                else
                begin
                    state_next = ST_D_EMIT;
                end
            end

            ST_D_EMIT:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    ld_strip_valid = 1'b1;
                    ld_x           = COORD_W'(xs_reg);
                    ld_y           = COORD_W'(row_reg);
                    ld_w           = SIZE_W'(xend_reg - {1'b0, xs_reg});
                    ld_h           = SIZE_W'(yend_reg - {1'b0, row_reg});
                    ld_last        = (pend_reg == '0) ||
                                     (n_reg == STRIP_N_W'(MAX_STRIPS - 1));
                    n_next         = n_reg + STRIP_N_W'(1);
                    state_next     = ld_last ? ST_IDLE : ST_D_FIND;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            enable_reg  <= 1'b1;
            count_reg   <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
            if (load)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        xmask_reg   <= xmask_next;
        y_rd_reg    <= y_rd_next;
        y_last_reg  <= y_last_next;
        y_wr_reg    <= y_wr_next;
        chk_reg     <= chk_next;
        hit_acc_reg <= hit_acc_next;
        row_reg     <= row_next;
        pend_reg    <= pend_next;
        strip_reg   <= strip_next;
        xs_reg      <= xs_next;
        xend_reg    <= xend_next;
        yend_reg    <= yend_next;
        n_reg       <= n_next;
        if (load)
        begin
            o_hit_reg         <= ld_hit;
            o_strip_valid_reg <= ld_strip_valid;
            o_x_reg           <= ld_x;
            o_y_reg           <= ld_y;
            o_w_reg           <= ld_w;
            o_h_reg           <= ld_h;
            o_count_reg       <= count_reg;
            o_last_reg        <= ld_last;
        end
    end

    assign out_valid   = o_valid_reg;
    assign hit         = o_hit_reg;
    assign strip_valid = o_strip_valid_reg;
    assign rect_x      = o_x_reg;
    assign rect_y      = o_y_reg;
    assign rect_width  = o_w_reg;
    assign rect_height = o_h_reg;
    assign mark_count  = o_count_reg;
    assign last        = o_last_reg;

endmodule

// ===== rtl/tob_checker.sv =====
// Port-level checks for the tile occupancy bitmap and the bind that attaches them.
module tob_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         hit,
    input logic                         strip_valid,
    input logic [tob_pkg::COORD_W-1:0]  rect_x,
    input logic [tob_pkg::COORD_W-1:0]  rect_y,
    input logic [tob_pkg::SIZE_W-1:0]   rect_width,
    input logic [tob_pkg::SIZE_W-1:0]   rect_height,
    input logic [tob_pkg::COUNT_W-1:0]  mark_count,
    input logic                         last
);
    import tob_pkg::*;

    // Only one item is in work, so an accepted item always blocks the next cycle.
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted back to back");

    // More strips of the same drain are still coming, so no new item may enter.
    a_open_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input open while a drain is unfinished");

    // A hit needs at least one mark and is never a drain result.
    a_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (mark_count != '0) && !strip_valid)
        else $error("hit reported without marks or on a strip");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(strip_valid) &&
            $stable(rect_x) && $stable(rect_y) && $stable(rect_width) &&
            $stable(rect_height) && $stable(mark_count) && $stable(last))
        else $error("stalled result changed");

endmodule

bind tile_occupancy_bitmap tob_checker u_tob_checker (.*);
